// ===== hw/rtl/cluster_bitmap_allocator_macros.svh =====
// Assertion macros used by the checker file of the cluster bitmap allocator.
`ifndef CLUSTER_BITMAP_ALLOCATOR_MACROS_SVH
`define CLUSTER_BITMAP_ALLOCATOR_MACROS_SVH

// Clocked assertion with an active-low reset that disables it.
`define CBA_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block clock and reset.
`define CBA_ASSERT(lbl, prop, msg) \
  `CBA_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== hw/rtl/cba_pkg.sv =====
// Shared constants, codes and controller/datapath structs of the cluster bitmap allocator.
package cba_pkg;

  localparam int MAX_CLUSTERS_DEF   = 65536;
  localparam int SCAN_WORD_BITS_DEF = 32;
  localparam int BLOCK_BYTES_DEF    = 2048;

  localparam int CNT_W    = 17;
  localparam int IDX_W    = 16;
  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;
  localparam int BLK_W    = 2;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam int OUT_W    = 24;

  localparam logic [CNT_W-1:0]   COUNT_RESET = 17'd65536;
  localparam logic [PADDR_W-1:0] ADDR_CLUSTER_COUNT = 3'd0;

  // Opcodes.
  localparam logic [OP_W-1:0] OP_ALLOC_FIRST = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC_GIVEN = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE        = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY       = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_USED     = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic accept;
    logic rd;
    logic eval;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic in_fail;
    logic eval_done;
    logic out_free;
  } stat_t;

endpackage

// ===== hw/rtl/cba_ctrl.sv =====
// Controller state machine of the cluster bitmap allocator.
module cba_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cba_pkg::stat_t stat_i,
  output cba_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = stat_i.in_fail ? S_DONE : S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d = stat_i.eval_done ? S_DONE : S_READ;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/cba_dp.sv =====
// Datapath of the cluster bitmap allocator: bitmap memory, scan logic and result registers.
module cba_dp #(
  parameter int MAX_CLUSTERS   = cba_pkg::MAX_CLUSTERS_DEF,
  parameter int SCAN_WORD_BITS = cba_pkg::SCAN_WORD_BITS_DEF,
  parameter int BLOCK_BYTES    = cba_pkg::BLOCK_BYTES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cba_pkg::cmd_t                cmd_i,
  output cba_pkg::stat_t               stat_o,
  input  logic [cba_pkg::OP_W-1:0]     in_op_i,
  input  logic [cba_pkg::IDX_W-1:0]    in_idx_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [cba_pkg::OUT_W-1:0]    out_data_o,
  input  logic                         cfg_we_i,
  input  logic [cba_pkg::CNT_W-1:0]    cfg_wdata_i,
  output logic [cba_pkg::CNT_W-1:0]    cfg_count_o
);

  localparam int WORDS  = MAX_CLUSTERS / SCAN_WORD_BITS;
  localparam int AW     = $clog2(WORDS);
  localparam int WB     = $clog2(SCAN_WORD_BITS);
  localparam int BLK_SH = $clog2(BLOCK_BYTES * 8);
  localparam int CW     = cba_pkg::CNT_W;

  logic [SCAN_WORD_BITS-1:0] mem [WORDS];
  logic [SCAN_WORD_BITS-1:0] rdata_q;
  logic [SCAN_WORD_BITS-1:0] mem_wd;
  logic                      mem_we;
  logic [AW-1:0]             mem_addr;

  logic [AW-1:0]   clr_q;
  logic [AW:0]     scan_q, hint_q;
  logic [CW-1:0]   count_q, live_n;
  logic [cba_pkg::OP_W-1:0]  op_q;
  logic [cba_pkg::IDX_W-1:0] idx_q;

  // Pending result fields.
  logic [cba_pkg::IDX_W-1:0]  res_num_q, res_num_d;
  logic [cba_pkg::STAT_W-1:0] res_st_q, res_st_d;
  logic                       res_was_q, res_was_d;
  logic [cba_pkg::BLK_W-1:0]  res_blk_q, res_blk_d;
  logic                       res_chg_q, res_chg_d;

  logic [cba_pkg::OUT_W-1:0] out_q;
  logic                      out_valid_q;

  logic [31:0] base, left, next_base, hint_base, alloc_c, idx_c;
  logic [SCAN_WORD_BITS-1:0] free_bits;
  logic [WB-1:0] pos, idx_pos;
  logic found, all_used, end_next, was, idx_oor, hint_end;
  logic eval_done;
  logic [AW:0] idx_word_q, in_word;

  // Effective count, limited to the capacity.
  always_comb begin
    live_n = (32'(count_q) > 32'(MAX_CLUSTERS)) ? CW'(MAX_CLUSTERS) : count_q;
  end

  // Checks made while the request word is taken.
  always_comb begin
    idx_oor   = {1'b0, in_idx_i} >= live_n;
    hint_base = 32'(hint_q) << WB;
    hint_end  = hint_base >= 32'(live_n);
    in_word   = (AW+1)'(in_idx_i >> WB);
  end

  // Search of the fetched word for the lowest free bit below the count.
  always_comb begin
    base      = 32'(scan_q) << WB;
    left      = 32'(live_n) - base;
    next_base = base + 32'(SCAN_WORD_BITS);
    end_next  = next_base >= 32'(live_n);
    for (int b = 0; b < SCAN_WORD_BITS; b++) begin
      free_bits[b] = ~rdata_q[b] & (32'(b) < left);
    end
    found = |free_bits;
    pos   = '0;
    for (int b = SCAN_WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) pos = WB'(b);
    end
    all_used = &rdata_q;
    alloc_c  = base + 32'(pos);
    idx_pos  = idx_q[WB-1:0];
    idx_c    = 32'(idx_q);
    was      = rdata_q[idx_pos];
    idx_word_q = (AW+1)'(idx_q >> WB);
  end

  // Result and bitmap update of the evaluate step.
  always_comb begin
    res_num_d = '0;
    res_st_d  = cba_pkg::ST_OK;
    res_was_d = 1'b0;
    res_blk_d = '0;
    res_chg_d = 1'b0;
    mem_we    = 1'b0;
    mem_wd    = rdata_q;
    eval_done = 1'b1;
    case (op_q)
      cba_pkg::OP_ALLOC_FIRST: begin
        if (found) begin
          mem_we    = cmd_i.eval;
          mem_wd    = rdata_q | (SCAN_WORD_BITS'(1) << pos);
          res_num_d = alloc_c[cba_pkg::IDX_W-1:0];
          res_blk_d = cba_pkg::BLK_W'(alloc_c >> BLK_SH);
          res_chg_d = 1'b1;
        end else if (end_next) begin
          res_st_d = cba_pkg::ST_FULL;
        end else begin
          eval_done = 1'b0;
        end
      end
      cba_pkg::OP_ALLOC_GIVEN: begin
        res_was_d = was;
        if (was) begin
          res_st_d = cba_pkg::ST_USED;
        end else begin
          mem_we    = cmd_i.eval;
          mem_wd    = rdata_q | (SCAN_WORD_BITS'(1) << idx_pos);
          res_num_d = idx_q;
          res_blk_d = cba_pkg::BLK_W'(idx_c >> BLK_SH);
          res_chg_d = 1'b1;
        end
      end
      cba_pkg::OP_FREE: begin
        mem_we    = cmd_i.eval;
        mem_wd    = rdata_q & ~(SCAN_WORD_BITS'(1) << idx_pos);
        res_was_d = was;
        res_num_d = idx_q;
        res_blk_d = cba_pkg::BLK_W'(idx_c >> BLK_SH);
        res_chg_d = was;
      end
      default: begin
        res_was_d = was;
        res_num_d = idx_q;
        res_blk_d = cba_pkg::BLK_W'(idx_c >> BLK_SH);
      end
    endcase
    if (cmd_i.clear) begin
      mem_we = 1'b1;
      mem_wd = '0;
    end
  end

  assign mem_addr = cmd_i.clear ? clr_q : scan_q[AW-1:0];

  // Bitmap memory with a registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    if (cmd_i.rd) rdata_q <= mem[mem_addr];
  end

  // Control registers: clear sweep, scan hint, count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      hint_q      <= '0;
      count_q     <= cba_pkg::COUNT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) clr_q <= clr_q + 1'b1;
      if (cfg_we_i) count_q <= cfg_wdata_i;
      // Every word below the hint is completely used.
      if (cmd_i.eval) begin
        if (op_q == cba_pkg::OP_ALLOC_FIRST && !found && all_used && scan_q == hint_q) begin
          hint_q <= scan_q + 1'b1;
        end else if (op_q == cba_pkg::OP_FREE && idx_word_q < hint_q) begin
          hint_q <= idx_word_q;
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request, scan position and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q     <= in_op_i;
      idx_q    <= in_idx_i;
      scan_q   <= (in_op_i == cba_pkg::OP_ALLOC_FIRST) ? hint_q : in_word;
      res_num_q <= '0;
      res_was_q <= 1'b0;
      res_blk_q <= '0;
      res_chg_q <= 1'b0;
      res_st_q  <= (in_op_i == cba_pkg::OP_ALLOC_FIRST) ? cba_pkg::ST_FULL : cba_pkg::ST_RANGE;
    end
    if (cmd_i.eval) begin
      if (op_q == cba_pkg::OP_ALLOC_FIRST && !found) scan_q <= scan_q + 1'b1;
      res_num_q <= res_num_d;
      res_st_q  <= res_st_d;
      res_was_q <= res_was_d;
      res_blk_q <= res_blk_d;
      res_chg_q <= res_chg_d;
    end
    if (cmd_i.load_out) begin
      out_q <= {2'b00, res_chg_q, res_blk_q, res_was_q, res_st_q, res_num_q};
    end
  end

  always_comb begin
    stat_o.clr_last  = clr_q == AW'(WORDS - 1);
    stat_o.in_fail   = (in_op_i == cba_pkg::OP_ALLOC_FIRST) ? hint_end : idx_oor;
    stat_o.eval_done = eval_done;
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_count_o = count_q;

endmodule

// ===== hw/rtl/cluster_bitmap_allocator.sv =====
// Top level of the first-fit cluster bitmap allocator.
// The block keeps one used bit per cluster and serves one request word at a time.
// Slave stream: s_tuser carries the opcode, s_tdata the cluster index.
// Master stream: one result word per request with number, status, prior bit,
// bitmap block and a changed flag.
// APB port: register cluster_count at 0; user writes only while idle, unenforced.
// After reset a clearing pass writes every bitmap word, one per cycle,
// MAX_CLUSTERS / SCAN_WORD_BITS words (2048 by default), with s_tready low.
// Claim, free and query go from acceptance to result in steps: memory read,
// evaluate and write back, result load; a request that fails its range check
// goes straight to the result load. Allocate-first reads and evaluates words in turn
// from a hint that points at the lowest word that may hold a free bit.
// A finished result waits in the output register while the master side stalls;
// the next request is taken meanwhile, and its result is held until the
// output register is free.
module cluster_bitmap_allocator #(
  parameter int MAX_CLUSTERS   = cba_pkg::MAX_CLUSTERS_DEF,
  parameter int SCAN_WORD_BITS = cba_pkg::SCAN_WORD_BITS_DEF,
  parameter int BLOCK_BYTES    = cba_pkg::BLOCK_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [cba_pkg::IDX_W-1:0]     s_tdata,  // [15:0] cluster_index
  input  logic [cba_pkg::OP_W-1:0]      s_tuser,  // [1:0] opcode
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [15:0] cluster_number, [17:16] status, [18] bit_was_used,
  // [20:19] changed_block, [21] block_changed, [23:22] zero
  output logic [cba_pkg::OUT_W-1:0]     m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cba_pkg::PADDR_W-1:0]   paddr,
  input  logic [cba_pkg::PDATA_W-1:0]   pwdata,
  output logic [cba_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  cba_pkg::cmd_t  cmd;
  cba_pkg::stat_t stat;
  logic [cba_pkg::CNT_W-1:0] count;
  logic cfg_we;

  // Register write at the access phase.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == cba_pkg::ADDR_CLUSTER_COUNT);
  assign prdata = (paddr == cba_pkg::ADDR_CLUSTER_COUNT) ? cba_pkg::PDATA_W'(count) : '0;

  cba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid),
    .in_ready_o (s_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cba_dp #(
    .MAX_CLUSTERS   (MAX_CLUSTERS),
    .SCAN_WORD_BITS (SCAN_WORD_BITS),
    .BLOCK_BYTES    (BLOCK_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_op_i     (s_tuser),
    .in_idx_i    (s_tdata),
    .out_ready_i (m_tready),
    .out_valid_o (m_tvalid),
    .out_data_o  (m_tdata),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (pwdata[cba_pkg::CNT_W-1:0]),
    .cfg_count_o (count)
  );

endmodule

// ===== hw/rtl/cba_checker.sv =====
// Port-level checker of the cluster bitmap allocator and its bind.
`include "cluster_bitmap_allocator_macros.svh"

module cba_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [cba_pkg::IDX_W-1:0]   s_tdata,
  input logic [cba_pkg::OP_W-1:0]    s_tuser,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [cba_pkg::OUT_W-1:0]   m_tdata,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [cba_pkg::PADDR_W-1:0] paddr,
  input logic [cba_pkg::PDATA_W-1:0] pwdata,
  input logic [cba_pkg::PDATA_W-1:0] prdata,
  input logic                        pready
);

  // A stalled result word stays offered.
  `CBA_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result word dropped while stalled")

  // A failed request reports no cluster and no change.
  `CBA_ASSERT(a_fail_zero, m_tvalid && m_tdata[17:16] != cba_pkg::ST_OK |-> m_tdata[15:0] == 16'd0 && m_tdata[21] == 1'b0 && m_tdata[20:19] == 2'd0, "failure word carries data")

  // A claim of a used cluster reports the bit as used.
  `CBA_ASSERT(a_used_was, m_tvalid && m_tdata[17:16] == cba_pkg::ST_USED |-> m_tdata[18], "used status without used bit")

  // The clearing pass keeps the request side closed right after reset.
  `CBA_ASSERT(a_clear_closed, !$past(rst_ni) |-> !s_tready, "request taken during clearing pass")

endmodule

bind cluster_bitmap_allocator cba_checker u_cba_checker (.*);
